// ===== rtl/advert_record_parser_macros.svh =====
// Assertion macros for the advert record parser
`ifndef ADVERT_RECORD_PARSER_MACROS_SVH
`define ADVERT_RECORD_PARSER_MACROS_SVH

// same-cycle implication
`define ARP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("advert_record_parser: assertion failed");

// next-cycle implication
`define ARP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("advert_record_parser: assertion failed");

`endif

// ===== rtl/arp_pkg.sv =====
// Package: types and constants of the advert record parser
package arp_pkg;

	localparam int MAX_DATA_DEF = 32;
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = $clog2(QDEPTH);
	localparam int QCNT_W       = $clog2(QDEPTH + 1);
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOCATION = 2'd0,
		REG_FEATURE1 = 2'd1,
		REG_FEATURE2 = 2'd2,
		REG_NAME     = 2'd3
	} reg_idx_t;

	localparam logic [CFG_DATA_W-1:0] LOCATION_RST = 3'd4;
	localparam logic [CFG_DATA_W-1:0] FEATURE1_RST = 3'd5;
	localparam logic [CFG_DATA_W-1:0] FEATURE2_RST = 3'd6;
	localparam logic [CFG_DATA_W-1:0] NAME_RST     = 3'd7;

	localparam logic KIND_NAME    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] location_bit;
		logic [CFG_DATA_W-1:0] feature1_bit;
		logic [CFG_DATA_W-1:0] feature2_bit;
		logic [CFG_DATA_W-1:0] name_bit;
	} arp_cfg_t;

	typedef struct packed {
		logic              kind;
		logic [7:0]        name_char;
		logic [7:0]        flag_byte;
		logic signed [31:0] latitude;
		logic signed [31:0] longitude;
		logic [15:0]       extra_one;
		logic [15:0]       extra_two;
		logic [4:0]        name_count;
		logic              record_ok;
		logic              last;
	} arp_result_t;

	// up to two result words per byte, first in r0
	typedef struct packed {
		logic [1:0]  n;
		arp_result_t r0;
		arp_result_t r1;
	} arp_push_t;

endpackage

// ===== rtl/arp_if.sv =====
// Interfaces: byte input channel and result word channel
interface arp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, data_byte, final_byte, input ready);
	modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface arp_out_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [7:0]         name_char;
	logic [7:0]         flag_byte;
	logic signed [31:0] latitude;
	logic signed [31:0] longitude;
	logic [15:0]        extra_one;
	logic [15:0]        extra_two;
	logic [4:0]         name_count;
	logic               record_ok;
	logic               last;

	modport source (output valid, kind, name_char, flag_byte, latitude, longitude,
		extra_one, extra_two, name_count, record_ok, last, input ready);
	modport sink   (input valid, kind, name_char, flag_byte, latitude, longitude,
		extra_one, extra_two, name_count, record_ok, last, output ready);
endinterface

// ===== rtl/arp_parser.sv =====
// Record parser: position counter, field registers and result word build
module arp_parser #(
	parameter int MAX_DATA = arp_pkg::MAX_DATA_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [7:0]       data_byte,
	input  logic             final_byte,
	input  arp_pkg::arp_cfg_t cfg,
	output arp_pkg::arp_push_t push
);
	import arp_pkg::*;

	localparam int NAME_LIMIT = ((MAX_DATA - 1) < 31) ? (MAX_DATA - 1) : 31;

	logic [7:0]  pos_q;
	logic [7:0]  flags_q;
	logic [31:0] lat_q, lon_q;
	logic [15:0] x1_q, x2_q;
	logic [4:0]  kept_q;

	logic [7:0]  flags_eff;
	logic        has_loc, has_f1, has_f2, has_name;
	logic [3:0]  f1_start, f2_start, fixed_end;
	logic        pos_nz, in_fixed, name_go, ok;
	logic [7:0]  lane_l, lane_1, lane_2;
	logic [31:0] lat_d, lon_d;
	logic [15:0] x1_d, x2_d;
	logic [4:0]  kept_d;
	arp_result_t name_r, sum_r;

	always_comb begin
		flags_eff = (pos_q == 8'd0) ? data_byte : flags_q;
		has_loc   = flags_eff[cfg.location_bit];
		has_f1    = flags_eff[cfg.feature1_bit];
		has_f2    = flags_eff[cfg.feature2_bit];
		has_name  = flags_eff[cfg.name_bit];
		f1_start  = has_loc ? 4'd9 : 4'd1;
		f2_start  = f1_start + (has_f1 ? 4'd2 : 4'd0);
		fixed_end = f2_start + (has_f2 ? 4'd2 : 4'd0);
		pos_nz    = (pos_q != 8'd0);
		in_fixed  = pos_nz && (pos_q < {4'd0, fixed_end});
		name_go   = pos_nz && !in_fixed && has_name && (kept_q < 5'(NAME_LIMIT));
		ok        = ({1'b0, pos_q} + 9'd1) >= {5'd0, fixed_end};
		lane_l    = pos_q - 8'd1;
		lane_1    = pos_q - {4'd0, f1_start};
		lane_2    = pos_q - {4'd0, f2_start};

		lat_d  = lat_q;
		lon_d  = lon_q;
		x1_d   = x1_q;
		x2_d   = x2_q;
		if (in_fixed) begin
			if (has_loc && pos_q < 8'd5) begin
				lat_d[lane_l[1:0]*8 +: 8] = data_byte;
			end else if (has_loc && pos_q < 8'd9) begin
				lon_d[lane_l[1:0]*8 +: 8] = data_byte;
			end else if (has_f1 && pos_q >= {4'd0, f1_start}
					&& pos_q < {4'd0, f1_start} + 8'd2) begin
				x1_d[lane_1[0]*8 +: 8] = data_byte;
			end else if (has_f2 && pos_q >= {4'd0, f2_start}) begin
				x2_d[lane_2[0]*8 +: 8] = data_byte;
			end
		end
		kept_d = kept_q + (name_go ? 5'd1 : 5'd0);
	end

	always_comb begin
		name_r           = '0;
		name_r.kind      = KIND_NAME;
		name_r.name_char = data_byte;
		name_r.last      = !final_byte;

		sum_r            = '0;
		sum_r.kind       = KIND_SUMMARY;
		sum_r.flag_byte  = flags_eff;
		sum_r.latitude   = (ok && has_loc) ? lat_d : 32'd0;
		sum_r.longitude  = (ok && has_loc) ? lon_d : 32'd0;
		sum_r.extra_one  = (ok && has_f1) ? x1_d : 16'd0;
		sum_r.extra_two  = (ok && has_f2) ? x2_d : 16'd0;
		sum_r.name_count = kept_d;
		sum_r.record_ok  = ok;
		sum_r.last       = 1'b1;

		push.n  = go ? ({1'b0, name_go} + {1'b0, final_byte}) : 2'd0;
		push.r0 = name_go ? name_r : sum_r;
		push.r1 = sum_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			flags_q <= '0;
			lat_q   <= '0;
			lon_q   <= '0;
			x1_q    <= '0;
			x2_q    <= '0;
			kept_q  <= '0;
		end else if (go) begin
			if (final_byte) begin
				pos_q   <= '0;
				flags_q <= '0;
				lat_q   <= '0;
				lon_q   <= '0;
				x1_q    <= '0;
				x2_q    <= '0;
				kept_q  <= '0;
			end else begin
				if (pos_q != 8'd255) begin
					pos_q <= pos_q + 8'd1;
				end
				flags_q <= flags_eff;
				lat_q   <= lat_d;
				lon_q   <= lon_d;
				x1_q    <= x1_d;
				x2_q    <= x2_d;
				kept_q  <= kept_d;
			end
		end
	end

endmodule

// ===== rtl/arp_result_fifo.sv =====
// Result queue: takes up to two words a cycle, gives one
module arp_result_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  arp_pkg::arp_push_t           push,
	input  logic                         pop,
	output arp_pkg::arp_result_t         head,
	output logic [arp_pkg::QCNT_W-1:0]   level
);
	import arp_pkg::*;

	arp_result_t       mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [QPTR_W-1:0] wr_nxt;

	assign wr_nxt = wr_q + QPTR_W'(1);
	assign head   = mem_q[rd_q];
	assign level  = cnt_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_nxt] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push.n);
			rd_q  <= rd_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(push.n) - QCNT_W'(pop);
		end
	end

endmodule

// ===== rtl/advert_record_parser.sv =====
// Top level: advert record parser
// Data path: an accepted byte is registered in the input stage and is parsed from there
// into the result queue; its result words are taken from the queue head.
// Throughput: one byte per cycle while the queue has room for two words; a name byte that
// is also the final byte gives two words, and the four-word queue sets the slack.
// Reset (arst_n low): record state cleared, flag positions back to 4, 5, 6, 7.
module advert_record_parser #(
	parameter int MAX_DATA = arp_pkg::MAX_DATA_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	arp_in_if.sink                            in,
	arp_out_if.source                         out,
	input  logic                              cfg_we,
	input  arp_pkg::reg_idx_t                 cfg_index,
	input  logic [arp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import arp_pkg::*;
	`include "advert_record_parser_macros.svh"

	arp_cfg_t          cfg_q;
	logic              s1_valid_q;
	logic [7:0]        byte_s1;
	logic              fin_s1;
	logic              go;
	arp_push_t         push;
	arp_result_t       head;
	logic [QCNT_W-1:0] level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.location_bit <= LOCATION_RST;
			cfg_q.feature1_bit <= FEATURE1_RST;
			cfg_q.feature2_bit <= FEATURE2_RST;
			cfg_q.name_bit     <= NAME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOCATION: cfg_q.location_bit <= cfg_data;
				REG_FEATURE1: cfg_q.feature1_bit <= cfg_data;
				REG_FEATURE2: cfg_q.feature2_bit <= cfg_data;
				REG_NAME:     cfg_q.name_bit     <= cfg_data;
				default: ;
			endcase
		end
	end

	// parse only with room for two words
	assign go       = s1_valid_q && (level <= QCNT_W'(QDEPTH - 2));
	assign in.ready = !s1_valid_q || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in.ready) begin
			s1_valid_q <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			byte_s1 <= in.data_byte;
			fin_s1  <= in.final_byte;
		end
	end

	arp_parser #(.MAX_DATA(MAX_DATA)) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.data_byte  (byte_s1),
		.final_byte (fin_s1),
		.cfg        (cfg_q),
		.push       (push)
	);

	arp_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (out.valid && out.ready),
		.head   (head),
		.level  (level)
	);

	assign out.valid      = (level != '0);
	assign out.kind       = head.kind;
	assign out.name_char  = head.name_char;
	assign out.flag_byte  = head.flag_byte;
	assign out.latitude   = head.latitude;
	assign out.longitude  = head.longitude;
	assign out.extra_one  = head.extra_one;
	assign out.extra_two  = head.extra_two;
	assign out.name_count = head.name_count;
	assign out.record_ok  = head.record_ok;
	assign out.last       = head.last;

	`ARP_ASSERT_NOW(a_queue_bound, 1'b1, level <= QCNT_W'(QDEPTH))
	`ARP_ASSERT_NOW(a_summary_last, out.valid && (out.kind == KIND_SUMMARY), out.last)
	`ARP_ASSERT_NOW(a_no_overwrite, in.valid && in.ready && s1_valid_q, go)
	`ARP_ASSERT_NEXT(a_stage_loads, in.valid && in.ready, s1_valid_q)

endmodule
